FILE: hw/rtl/nearest_texture_sampler_assert.svh
// Assertion macros shared by the sampler RTL.
// Both forms sample on the rising edge of clk and are disabled while rst_n is low.
`ifndef NEAREST_TEXTURE_SAMPLER_ASSERT_SVH
`define NEAREST_TEXTURE_SAMPLER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NTS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/nts_pkg.sv
package nts_pkg;

  localparam int ADDR_W        = 12;
  localparam int STORE_DEPTH   = 4096;
  localparam int DATA_W        = 32;
  localparam int COORD_W       = 24;
  localparam int SIZE_REG_W    = 7;
  localparam int MODE_W        = 2;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 7;
  localparam int IN_TDATA_W    = 96;
  localparam int OUT_TDATA_W   = 32;
  localparam int MAX_DIM_DEF   = 64;
  localparam int FRAC_BITS_DEF = 16;

  typedef enum logic [MODE_W-1:0] {
    ADDR_REPEAT = 2'd0,
    ADDR_MIRROR = 2'd1,
    ADDR_CLAMP  = 2'd2
  } addr_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEX_WIDTH  = 2'd0,
    REG_TEX_HEIGHT = 2'd1,
    REG_MODE_U     = 2'd2,
    REG_MODE_V     = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } opcode_t;

endpackage

FILE: hw/rtl/nts_ram.sv
module nts_ram #(
  parameter int WIDTH = nts_pkg::DATA_W,
  parameter int DEPTH = nts_pkg::STORE_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/nts_coord.sv
module nts_coord #(
  parameter int FRAC_BITS = nts_pkg::FRAC_BITS_DEF,
  parameter int MAX_DIM   = nts_pkg::MAX_DIM_DEF
) (
  input  logic                                           clk,
  input  logic                                           adv,
  input  logic signed [nts_pkg::COORD_W-1:0]             coord,
  input  nts_pkg::addr_mode_t                            mode,
  input  logic [$clog2(MAX_DIM+1)-1:0]                   size,
  output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1)-1:0] texel_r
);
  import nts_pkg::*;

  localparam int WB = FRAC_BITS + 1;
  localparam int EW = (FRAC_BITS + 2 > COORD_W) ? FRAC_BITS + 2 : COORD_W;
  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int TW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int PW = WB + DW;

  localparam logic [WB:0]          ONE_X = (WB + 1)'(1) << FRAC_BITS;
  localparam logic [WB:0]          TWO_X = (WB + 1)'(1) << (FRAC_BITS + 1);
  localparam logic signed [EW-1:0] ONE_E = EW'(1) << FRAC_BITS;

  logic signed [EW-1:0] ext;
  logic [WB:0]          fold;
  logic [WB:0]          fold_back;
  logic [WB-1:0]        wrap;
  logic [WB-1:0]        wrap_r;
  logic [PW-1:0]        prod;
  logic [DW-1:0]        pos;
  logic [DW-1:0]        lim;

  assign ext       = EW'(coord);
  assign fold      = {1'b0, ext[FRAC_BITS:0]};
  assign fold_back = TWO_X - fold;

  // Wrap the coordinate into 0..1 with one integer bit kept for the value one.
  always_comb begin
    case (mode)
      ADDR_REPEAT: begin
        wrap = {1'b0, ext[FRAC_BITS-1:0]};
      end
      ADDR_MIRROR: begin
        wrap = (fold <= ONE_X) ? fold[WB-1:0] : fold_back[WB-1:0];
      end
      default: begin
        if (ext < 0) begin
          wrap = '0;
        end else if (ext > ONE_E) begin
          wrap = ONE_X[WB-1:0];
        end else begin
          wrap = ext[WB-1:0];
        end
      end
    endcase
  end

  assign prod = PW'(wrap_r) * PW'(size);
  assign pos  = prod[FRAC_BITS +: DW];
  assign lim  = size - DW'(1);

  always_ff @(posedge clk) begin
    if (adv) begin
      wrap_r  <= wrap;
      texel_r <= (pos > lim) ? TW'(lim) : TW'(pos);
    end
  end

endmodule

FILE: hw/rtl/nearest_texture_sampler.sv
// Nearest-neighbor RGBA8 texture sampler with per-axis repeat, mirror and clamp.
// A sample passes the wrap, texel index, RAM read and output registers in order.
// Throughput: one item per cycle unless stalled; the texel RAM does one write or read per cycle.
// A stalled result holds the RAM output and stops intake until the output register frees.
// Synchronous active-low reset clears the pipeline and sets size 1x1 with repeat modes.
// Texel RAM contents are not cleared by reset and must be written before they are sampled.
`include "nearest_texture_sampler_assert.svh"

module nearest_texture_sampler #(
  parameter int MAX_DIM   = nts_pkg::MAX_DIM_DEF,
  parameter int FRAC_BITS = nts_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // Fields from bit 0: write_index[11:0], write_rgba[43:12], coord_u[67:44],
  // coord_v[91:68], zero fill [95:92].
  input  logic [nts_pkg::IN_TDATA_W-1:0]   in_tdata,
  // Fields from bit 0: opcode.
  input  logic [0:0]                       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // Fields from bit 0: red[7:0], green[15:8], blue[23:16], alpha[31:24].
  output logic [nts_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [nts_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [nts_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import nts_pkg::*;

  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int TW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int SW = (DW > SIZE_REG_W) ? DW : SIZE_REG_W;
  localparam int PW = (TW + DW + 1 > ADDR_W) ? TW + DW + 1 : ADDR_W;

  typedef struct packed {
    logic    vld;
    opcode_t op;
  } stage_ctl_t;

  typedef struct packed {
    logic [ADDR_W-1:0] index;
    logic [DATA_W-1:0] rgba;
  } wr_pay_t;

  logic [SIZE_REG_W-1:0] tex_width_r;
  logic [SIZE_REG_W-1:0] tex_height_r;
  logic [MODE_W-1:0]     mode_u_r;
  logic [MODE_W-1:0]     mode_v_r;

  stage_ctl_t s1_ctl_r, s2_ctl_r;
  wr_pay_t    s1_pay_r, s2_pay_r;

  logic                  rd_pend_r, rd_pend_nxt;
  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  logic            adv;
  logic            out_free;
  logic [DW-1:0]   eff_w;
  logic [DW-1:0]   eff_h;
  logic [TW-1:0]   tex_x;
  logic [TW-1:0]   tex_y;
  logic [PW-1:0]   lin_idx;
  logic            ram_we;
  logic            ram_re;
  logic [DATA_W-1:0] ram_rdata;

  function automatic logic [DW-1:0] eff_size(input logic [SIZE_REG_W-1:0] s);
    logic [DW-1:0] res;
    if (s == '0) begin
      res = DW'(1);
    end else if (SW'(s) > SW'(MAX_DIM)) begin
      res = DW'(MAX_DIM);
    end else begin
      res = DW'(s);
    end
    return res;
  endfunction

  assign eff_w = eff_size(tex_width_r);
  assign eff_h = eff_size(tex_height_r);

  // A pending RAM read can only leave when the output register is free.
  assign out_free  = !out_tvalid_r || out_tready;
  assign adv       = !rd_pend_r || out_free;
  assign in_tready = rst_n && adv;
  assign cfg_ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_width_r  <= SIZE_REG_W'(1);
      tex_height_r <= SIZE_REG_W'(1);
      mode_u_r     <= ADDR_REPEAT;
      mode_v_r     <= ADDR_REPEAT;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_TEX_WIDTH:  tex_width_r  <= cfg_data;
        REG_TEX_HEIGHT: tex_height_r <= cfg_data;
        REG_MODE_U:     mode_u_r     <= cfg_data[MODE_W-1:0];
        REG_MODE_V:     mode_v_r     <= cfg_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  nts_coord #(
    .FRAC_BITS(FRAC_BITS),
    .MAX_DIM  (MAX_DIM)
  ) u_coord_u (
    .clk    (clk),
    .adv    (adv),
    .coord  (in_tdata[67:44]),
    .mode   (addr_mode_t'(mode_u_r)),
    .size   (eff_w),
    .texel_r(tex_x)
  );

  nts_coord #(
    .FRAC_BITS(FRAC_BITS),
    .MAX_DIM  (MAX_DIM)
  ) u_coord_v (
    .clk    (clk),
    .adv    (adv),
    .coord  (in_tdata[91:68]),
    .mode   (addr_mode_t'(mode_v_r)),
    .size   (eff_h),
    .texel_r(tex_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
      s2_ctl_r <= '0;
    end else if (adv) begin
      s1_ctl_r <= '{vld: in_tvalid, op: opcode_t'(in_tuser[0])};
      s2_ctl_r <= s1_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pay_r <= '{index: in_tdata[11:0], rgba: in_tdata[43:12]};
      s2_pay_r <= s1_pay_r;
    end
  end

  // The linear index wraps to the store depth.
  assign lin_idx = PW'(tex_y) * PW'(eff_w) + PW'(tex_x);

  assign ram_we = adv && s2_ctl_r.vld && (s2_ctl_r.op == OP_WRITE);
  assign ram_re = adv && s2_ctl_r.vld && (s2_ctl_r.op == OP_SAMPLE);

  nts_ram #(
    .WIDTH(DATA_W),
    .DEPTH(STORE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(s2_pay_r.index),
    .wdata(s2_pay_r.rgba),
    .re   (ram_re),
    .raddr(lin_idx[ADDR_W-1:0]),
    .rdata(ram_rdata)
  );

  always_comb begin
    rd_pend_nxt    = adv ? ram_re : rd_pend_r;
    out_tvalid_nxt = out_tvalid_r;
    if (rd_pend_r && out_free) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      rd_pend_r    <= rd_pend_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend_r && out_free) begin
      out_tdata_r <= ram_rdata;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  `NTS_ASSERT_SAME(a_ram_one_port, ram_we, !ram_re, "RAM write and read in one cycle")
  `NTS_ASSERT_NEXT(a_rdata_held, rd_pend_r && !out_free, $stable(ram_rdata),
                   "RAM read data changed while the result was stalled")
  `NTS_ASSERT_SAME(a_out_from_read, $rose(out_tvalid_r), $past(rd_pend_r),
                   "result raised without a pending texel read")
  `NTS_ASSERT_NEXT(a_stall_keeps_pend, rd_pend_r && !out_free, rd_pend_r && out_tvalid_r,
                   "stalled texel read or waiting result was dropped")

endmodule
